// ===== rtl/dtif_pkg.sv =====
// Shared constants and types of the dead time interval filter.
`default_nettype none

package dtif_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 48;
  localparam int unsigned RES_W           = 48;
  localparam int unsigned MAX_RES         = 4;
  localparam int unsigned CNT_W           = $clog2(MAX_RES + 1);
  localparam int unsigned PTR_W           = $clog2(MAX_RES);
  localparam int unsigned CFG_IDX_W       = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RESOLUTION = 1'b0,
    REG_TIME_MODE  = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [CNT_W-1:0]   count;
    logic [MAX_RES-1:0] endm;
  } res_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/dtif_core.sv =====
// Input register, configuration, series state and per-item result list.
`default_nettype none

module dtif_core #(
  parameter int unsigned VALUE_WIDTH = dtif_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   cfg_we_i,
  input  wire logic [dtif_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  wire logic [dtif_pkg::RES_W-1:0]             cfg_data_i,
  input  wire logic                                   in_valid_i,
  output logic                                        in_ready_o,
  input  wire logic [VALUE_WIDTH-1:0]                 in_value_i,
  input  wire logic                                   in_eos_i,
  input  wire logic                                   buf_free_i,
  output logic                                        load_o,
  output dtif_pkg::res_ctl_t                          res_ctl_o,
  output logic [dtif_pkg::MAX_RES-1:0][VALUE_WIDTH-1:0] res_vals_o
);

  localparam int unsigned VW = VALUE_WIDTH;
  localparam int unsigned CW = (VW > dtif_pkg::RES_W) ? VW : dtif_pkg::RES_W;
  localparam int unsigned PW = dtif_pkg::PTR_W;
  localparam int unsigned NW = dtif_pkg::CNT_W;

  function automatic logic [VW-1:0] sat_add(input logic [VW-1:0] a, input logic [VW-1:0] b);
    logic [VW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[VW] ? {VW{1'b1}} : s[VW-1:0];
  endfunction

  logic [dtif_pkg::RES_W-1:0] res_q;
  logic                       tm_q;

  logic          iv_q;
  logic [VW-1:0] ival_in_q;
  logic          ieos_q;
  logic          advance;

  logic          run_q, run_d, odd_q, odd_d, abs_q, abs_d, hp_q, hp_d, owed_q, owed_d;
  logic [VW-1:0] pend_q, pend_d, prev_q, prev_d, st_q, st_d;

  logic          take, det;
  logic [VW-1:0] ival, ibeg;
  logic [NW-1:0] cnt;
  logic [dtif_pkg::MAX_RES-1:0]         endm;
  logic [dtif_pkg::MAX_RES-1:0][VW-1:0] vals;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
      tm_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (dtif_pkg::cfg_reg_e'(cfg_index_i))
        dtif_pkg::REG_RESOLUTION: res_q <= cfg_data_i;
        dtif_pkg::REG_TIME_MODE:  tm_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign advance    = iv_q && buf_free_i;
  assign in_ready_o = !iv_q || advance;
  assign load_o     = advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q <= 1'b0;
    end else if (in_ready_o) begin
      iv_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      ival_in_q <= in_value_i;
      ieos_q    <= in_eos_i;
    end
  end

  always_comb begin
    run_d  = run_q;
    odd_d  = odd_q;
    abs_d  = abs_q;
    pend_d = pend_q;
    hp_d   = hp_q;
    prev_d = prev_q;
    st_d   = st_q;
    owed_d = owed_q;
    cnt    = '0;
    vals   = '0;
    endm   = '0;
    take   = 1'b0;
    ival   = '0;
    ibeg   = '0;

    if (tm_q) begin
      if (!hp_q) begin
        hp_d   = 1'b1;
        prev_d = ival_in_q;
      end else begin
        take   = 1'b1;
        ival   = (ival_in_q >= prev_q) ? ival_in_q - prev_q : '0;
        ibeg   = prev_q;
        prev_d = ival_in_q;
      end
    end else begin
      take = 1'b1;
      ival = ival_in_q;
    end

    det = CW'(ival) >= CW'(res_q);

    if (take) begin
      if (!run_q) begin
        if (!odd_q && det && !ieos_q) begin
          run_d  = 1'b1;
          pend_d = ival;
          st_d   = ibeg;
          owed_d = 1'b1;
        end
      end else if (abs_q) begin
        pend_d = sat_add(pend_q, ival);
        abs_d  = 1'b0;
      end else if (det) begin
        // close the pending interval
        if (tm_q) begin
          if (owed_d) begin
            vals[cnt[PW-1:0]] = st_d;
            cnt    = cnt + NW'(1);
            owed_d = 1'b0;
          end
          st_d = sat_add(st_d, pend_q);
          vals[cnt[PW-1:0]] = st_d;
        end else begin
          vals[cnt[PW-1:0]] = pend_q;
        end
        cnt    = cnt + NW'(1);
        pend_d = ival;
      end else begin
        pend_d = sat_add(pend_q, ival);
        if (!ieos_q) begin
          abs_d = 1'b1;
        end
      end
      odd_d = !odd_q;
    end

    if (ieos_q) begin
      // flush, mark the end, restart the series
      if (run_d) begin
        if (tm_q) begin
          if (owed_d) begin
            vals[cnt[PW-1:0]] = st_d;
            cnt = cnt + NW'(1);
          end
          vals[cnt[PW-1:0]] = sat_add(st_d, pend_d);
        end else begin
          vals[cnt[PW-1:0]] = pend_d;
        end
        cnt = cnt + NW'(1);
      end
      vals[cnt[PW-1:0]] = '0;
      endm[cnt[PW-1:0]] = 1'b1;
      cnt    = cnt + NW'(1);
      run_d  = 1'b0;
      odd_d  = 1'b0;
      abs_d  = 1'b0;
      pend_d = '0;
      hp_d   = 1'b0;
      prev_d = '0;
      st_d   = '0;
      owed_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      odd_q  <= 1'b0;
      abs_q  <= 1'b0;
      pend_q <= '0;
      hp_q   <= 1'b0;
      prev_q <= '0;
      st_q   <= '0;
      owed_q <= 1'b0;
    end else if (advance) begin
      run_q  <= run_d;
      odd_q  <= odd_d;
      abs_q  <= abs_d;
      pend_q <= pend_d;
      hp_q   <= hp_d;
      prev_q <= prev_d;
      st_q   <= st_d;
      owed_q <= owed_d;
    end
  end

  assign res_ctl_o.count = cnt;
  assign res_ctl_o.endm  = endm;
  assign res_vals_o      = vals;

`ifndef SYNTHESIS
  a_eos_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && ieos_q |=> !run_q && !hp_q && !abs_q)
    else $error("series state not cleared after end of stream");
  a_eos_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && ieos_q |-> (cnt != '0) && endm[cnt[PW-1:0] - PW'(1)])
    else $error("end of stream without end marker");
`endif

endmodule

`default_nettype wire

// ===== rtl/dtif_out_buf.sv =====
// Result list register that hands out one result per transfer.
`default_nettype none

module dtif_out_buf #(
  parameter int unsigned VALUE_WIDTH = dtif_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       rst_ni,
  input  wire logic                                       load_i,
  input  wire dtif_pkg::res_ctl_t                         res_ctl_i,
  input  wire logic [dtif_pkg::MAX_RES-1:0][VALUE_WIDTH-1:0] res_vals_i,
  output logic                                            free_o,
  output logic                                            out_valid_o,
  input  wire logic                                       out_ready_i,
  output logic [VALUE_WIDTH-1:0]                          out_value_o,
  output logic                                            out_endm_o,
  output logic                                            out_last_o
);

  localparam int unsigned NW = dtif_pkg::CNT_W;
  localparam int unsigned PW = dtif_pkg::PTR_W;

  logic [dtif_pkg::MAX_RES-1:0][VALUE_WIDTH-1:0] vals_q;
  logic [dtif_pkg::MAX_RES-1:0]                  endm_q;
  logic [NW-1:0] rem_q;
  logic [PW-1:0] ptr_q;
  logic          pop;

  assign out_valid_o = rem_q != '0;
  assign pop         = out_valid_o && out_ready_i;
  assign free_o      = (rem_q == '0) || ((rem_q == NW'(1)) && out_ready_i);
  assign out_value_o = vals_q[ptr_q];
  assign out_endm_o  = endm_q[ptr_q];
  assign out_last_o  = rem_q == NW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      ptr_q <= '0;
    end else if (load_i) begin
      rem_q <= res_ctl_i.count;
      ptr_q <= '0;
    end else if (pop) begin
      rem_q <= rem_q - NW'(1);
      ptr_q <= ptr_q + PW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      vals_q <= res_vals_i;
      endm_q <= res_ctl_i.endm;
    end
  end

`ifndef SYNTHESIS
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= NW'(dtif_pkg::MAX_RES))
    else $error("result count out of range");
  a_marker_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_endm_o |-> out_last_o && (out_value_o == '0))
    else $error("end marker not last or not zero");
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> (rem_q == '0) || (rem_q == NW'(1) && pop))
    else $error("result list overwritten before drained");
`endif

endmodule

`default_nettype wire

// ===== rtl/dead_time_interval_filter.sv =====
// Path: the input register holds each item, then its results load into the result list register.
// Throughput: one item per cycle while each item yields at most one result and the output is
// ready; an item with n results holds the input while the result list drains.
// Reset: asynchronous, clears resolution, time mode, series state and all valids.
// Top level of the dead time interval filter.
`default_nettype none

module dead_time_interval_filter #(
  parameter int unsigned VALUE_WIDTH = dtif_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [dtif_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [dtif_pkg::RES_W-1:0]           cfg_data_i,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  input  wire logic [((VALUE_WIDTH+7)/8)*8-1:0]     s_axis_tdata,  // sample_value
  input  wire logic                                 s_axis_tlast,  // end_of_stream
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  output logic [((VALUE_WIDTH+7)/8)*8-1:0]          m_axis_tdata,  // result_value
  output logic                                      m_axis_tuser,  // end_marker
  output logic                                      m_axis_tlast   // last_of_run
);

  localparam int unsigned DW = ((VALUE_WIDTH + 7) / 8) * 8;

  logic                load;
  logic                free;
  dtif_pkg::res_ctl_t  res_ctl;
  logic [dtif_pkg::MAX_RES-1:0][VALUE_WIDTH-1:0] res_vals;
  logic [VALUE_WIDTH-1:0] out_value;

  dtif_core #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_value_i (s_axis_tdata[VALUE_WIDTH-1:0]),
    .in_eos_i   (s_axis_tlast),
    .buf_free_i (free),
    .load_o     (load),
    .res_ctl_o  (res_ctl),
    .res_vals_o (res_vals)
  );

  dtif_out_buf #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (load),
    .res_ctl_i  (res_ctl),
    .res_vals_i (res_vals),
    .free_o     (free),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_value_o(out_value),
    .out_endm_o (m_axis_tuser),
    .out_last_o (m_axis_tlast)
  );

  assign m_axis_tdata = DW'(out_value);

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking testbench for the dead time interval filter stream block.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VW = dtif_pkg::VALUE_WIDTH_DEF;
  localparam int DW = ((VW + 7) / 8) * 8;
  localparam int RW = dtif_pkg::RES_W;
  localparam int IW = dtif_pkg::CFG_IDX_W;
  localparam logic [VW-1:0] VMAX = '1;
  localparam int IDLE_LIMIT = 1000;
  localparam int SETTLE = 8;
  localparam int RANDOM_ITEMS = 380;
  localparam int CALM_ITEMS = 60;

  typedef struct packed {
    logic [VW-1:0] value;
    logic          eos;
  } sample_t;

  typedef struct packed {
    logic [VW-1:0] value;
    logic          endm;
    logic          last;
  } result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [IW-1:0]        cfg_index_i = dtif_pkg::REG_RESOLUTION;
  logic [RW-1:0]        cfg_data_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [DW-1:0]        s_axis_tdata = '0;   // sample_value
  logic                 s_axis_tlast = 1'b0; // end_of_stream
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [DW-1:0]        m_axis_tdata;        // result_value
  logic                 m_axis_tuser;        // end_marker
  logic                 m_axis_tlast;        // last_of_run

  dead_time_interval_filter #(.VALUE_WIDTH(VW)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // predictor copy of registers and series state
  logic [VW-1:0] tau = '0;
  logic          ts_mode = 1'b0;
  logic          in_run, odd_idx, absorb_next, have_prev, base_owed;
  logic [VW-1:0] pend_sum, prev_ts, base_ts;

  sample_t sample_fifo[$];
  result_t due_results[$];
  sample_t in_flight;
  int      mismatch_count = 0;
  int      random_sent = 0;
  int      src_hold = 0;
  int      sink_hold = 0;
  int      idle_cycles = 0;
  bit      calm = 1'b0;

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  function automatic logic [VW-1:0] sat_sum(logic [VW-1:0] a, logic [VW-1:0] b);
    logic [VW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[VW] ? VMAX : s[VW-1:0];
  endfunction

  function automatic logic [VW-1:0] rand48();
    return VW'({$urandom(), $urandom()});
  endfunction

  task automatic clear_series();
    in_run = 1'b0;
    odd_idx = 1'b0;
    absorb_next = 1'b0;
    pend_sum = '0;
    have_prev = 1'b0;
    prev_ts = '0;
    base_ts = '0;
    base_owed = 1'b0;
  endtask

  task automatic append_result(ref result_t batch[$], input result_t r);
    batch.insert(batch.size(), r);
  endtask

  task automatic close_open(ref result_t batch[$]);
    if (ts_mode) begin
      if (base_owed) begin
        append_result(batch, result_t'{base_ts, 1'b0, 1'b0});
        base_owed = 1'b0;
      end
      base_ts = sat_sum(base_ts, pend_sum);
      append_result(batch, result_t'{base_ts, 1'b0, 1'b0});
    end else begin
      append_result(batch, result_t'{pend_sum, 1'b0, 1'b0});
    end
  endtask

  task automatic take_interval(logic [VW-1:0] len, logic eos, logic [VW-1:0] t0,
                               ref result_t batch[$]);
    if (!in_run) begin
      if (!odd_idx && len >= tau && !eos) begin
        in_run = 1'b1;
        pend_sum = len;
        base_ts = t0;
        base_owed = 1'b1;
      end
    end else if (absorb_next) begin
      pend_sum = sat_sum(pend_sum, len);
      absorb_next = 1'b0;
    end else if (len >= tau) begin
      close_open(batch);
      pend_sum = len;
    end else begin
      pend_sum = sat_sum(pend_sum, len);
      if (!eos) absorb_next = 1'b1;
    end
    odd_idx = !odd_idx;
  endtask

  task automatic filter_sample(sample_t s);
    result_t       batch[$];
    logic [VW-1:0] len;
    logic [VW-1:0] t0;
    if (ts_mode) begin
      if (!have_prev) begin
        have_prev = 1'b1;
        prev_ts = s.value;
      end else begin
        len = (s.value >= prev_ts) ? s.value - prev_ts : '0;
        t0 = prev_ts;
        prev_ts = s.value;
        take_interval(len, s.eos, t0, batch);
      end
    end else begin
      take_interval(s.value, s.eos, '0, batch);
    end
    if (s.eos) begin
      if (in_run) close_open(batch);
      append_result(batch, result_t'{'0, 1'b1, 1'b0});
      clear_series();
    end
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[i]) due_results.insert(due_results.size(), batch[i]);
  endtask

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic check_result();
    result_t want;
    if (due_results.size() == 0) begin
      report_mismatch($sformatf("result with none due: value=%h end=%b last=%b",
                                m_axis_tdata, m_axis_tuser, m_axis_tlast));
      return;
    end
    want = due_results.pop_front();
    if (m_axis_tdata[VW-1:0] !== want.value)
      report_mismatch($sformatf("value %h, want %h", m_axis_tdata, want.value));
    if (m_axis_tuser !== want.endm)
      report_mismatch($sformatf("end marker %b, want %b", m_axis_tuser, want.endm));
    if (m_axis_tlast !== want.last)
      report_mismatch($sformatf("last of run %b, want %b", m_axis_tlast, want.last));
  endtask

  // sample driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      src_hold <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) filter_sample(in_flight);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_hold > 0) begin
          src_hold <= src_hold - 1;
          s_axis_tvalid <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          src_hold <= $urandom_range(0, 9);
          s_axis_tvalid <= 1'b0;
        end else if (sample_fifo.size() > 0) begin
          in_flight = sample_fifo.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= DW'(in_flight.value);
          s_axis_tlast <= in_flight.eos;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_hold <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (sink_hold > 0) begin
        sink_hold <= sink_hold - 1;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        sink_hold <= $urandom_range(0, 9);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic write_reg(dtif_pkg::cfg_reg_e idx, logic [RW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == dtif_pkg::REG_RESOLUTION) tau = val[VW-1:0];
    else ts_mode = val[0];
  endtask

  task automatic add_item(logic [VW-1:0] v, logic e);
    sample_fifo.insert(sample_fifo.size(), sample_t'{v, e});
  endtask

  task automatic drain();
    while (sample_fifo.size() != 0 || s_axis_tvalid || due_results.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  function automatic logic [VW-1:0] pick_tau();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return VMAX;
      2: return rand48();
      default: return VW'($urandom_range(1, 3000));
    endcase
  endfunction

  function automatic logic [VW-1:0] pick_len();
    case ($urandom_range(0, 15))
      0, 1: return tau;
      2, 3: return (tau == '0) ? '0 : tau - 1'b1;
      4, 5, 6: return (tau == '0) ? '0 : rand48() % tau;
      7, 8: return sat_sum(tau, VW'($urandom_range(1, 16)));
      9, 10, 11, 12: return sat_sum(tau, VW'($urandom_range(0, 5000)));
      13: return rand48();
      default: return '0;
    endcase
  endfunction

  task automatic gen_series(int len, bit closes);
    logic [VW-1:0] stamp;
    logic [VW-1:0] step;
    logic [VW-1:0] val;
    stamp = ($urandom_range(0, 7) == 0) ? rand48() : VW'($urandom_range(0, 100000));
    for (int i = 0; i < len; i++) begin
      step = pick_len();
      if (ts_mode && $urandom_range(0, 11) == 0) stamp = (stamp > step) ? stamp - step : '0;
      else stamp = sat_sum(stamp, step);
      val = ts_mode ? stamp : step;
      if ($urandom_range(0, 9) == 0) val = rand48();
      add_item(val, closes && (i == len - 1));
      random_sent++;
    end
  endtask

  initial begin
    int series_n;
    clear_series();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_reg(dtif_pkg::REG_RESOLUTION, '0);
    write_reg(dtif_pkg::REG_TIME_MODE, 1'b0);
    add_item(48'd5, 1'b1);
    add_item(48'd0, 1'b0);
    add_item(VMAX, 1'b0);
    add_item(48'd3, 1'b1);
    drain();

    write_reg(dtif_pkg::REG_RESOLUTION, 48'd100);
    add_item(48'd50, 1'b0);
    add_item(48'd30, 1'b0);
    add_item(48'd200, 1'b0);
    add_item(48'd10, 1'b0);
    add_item(48'd20, 1'b0);
    add_item(48'd300, 1'b0);
    add_item(VMAX, 1'b0);
    add_item(48'd5, 1'b0);
    add_item(VMAX, 1'b0);
    add_item(48'd40, 1'b1);
    drain();

    write_reg(dtif_pkg::REG_TIME_MODE, 1'b1);
    add_item(48'd777, 1'b1);
    add_item(48'd1000, 1'b0);
    add_item(48'd900, 1'b0);
    add_item(48'd1250, 1'b0);
    add_item(48'd1400, 1'b0);
    add_item(48'd1430, 1'b0);
    add_item(48'd1500, 1'b0);
    add_item(VMAX, 1'b0);
    add_item(VMAX, 1'b1);
    add_item(48'd0, 1'b0);
    add_item(48'd500, 1'b1);
    drain();

    write_reg(dtif_pkg::REG_TIME_MODE, 1'b0);
    write_reg(dtif_pkg::REG_RESOLUTION, 48'd10);
    add_item(48'd20, 1'b0);
    add_item(48'd30, 1'b0);
    drain();
    write_reg(dtif_pkg::REG_TIME_MODE, 1'b1);
    add_item(48'd5000, 1'b0);
    add_item(48'd5100, 1'b1);
    drain();

    write_reg(dtif_pkg::REG_RESOLUTION, VMAX);
    while (random_sent < RANDOM_ITEMS) begin
      if (random_sent >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      if ($urandom_range(0, 2) != 0) write_reg(dtif_pkg::REG_RESOLUTION, pick_tau());
      if ($urandom_range(0, 2) == 0)
        write_reg(dtif_pkg::REG_TIME_MODE, RW'($urandom_range(0, 1)));
      series_n = $urandom_range(1, 4);
      for (int k = 0; k < series_n; k++)
        gen_series(($urandom_range(0, 7) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12),
                   !(k == series_n - 1 && $urandom_range(0, 3) == 0));
      drain();
    end

    if (mismatch_count == 0 && due_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== dead_time_interval_filter.f =====
rtl/dtif_pkg.sv
rtl/dtif_core.sv
rtl/dtif_out_buf.sv
rtl/dead_time_interval_filter.sv
bench/testbench.sv
